// ----- hw/rtl/mip_pkg.sv -----
// Shared types and constants for the inbound MQTT packet parser.
// No dependencies; imported by mip_utf8, mip_core and the top level.
package mip_pkg;

	localparam int DATA_W    = 8;
	localparam int RLEN_W    = 28;
	localparam int PKT_LEN_W = 17;
	localparam int TOPIC_W   = 16;
	localparam int PID_W     = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TOPIC_LEN  = 1'b1;

	localparam logic [PKT_LEN_W-1:0] MAX_PACKET_LEN_RST = 17'd1024;
	localparam logic [TOPIC_W-1:0]   MAX_TOPIC_LEN_RST  = 16'd127;

	localparam logic [3:0] T_CONNACK   = 4'd2;
	localparam logic [3:0] T_PUBLISH   = 4'd3;
	localparam logic [3:0] T_ACK_FIRST = 4'd4;
	localparam logic [3:0] T_ACK_LAST  = 4'd7;

	localparam logic [1:0] QOS_1 = 2'd1;
	localparam logic [1:0] QOS_2 = 2'd2;
	localparam logic [1:0] QOS_3 = 2'd3;

	typedef enum logic [3:0] {
		PH_TYPE       = 4'd0,
		PH_LEN        = 4'd1,
		PH_TLEN_HI    = 4'd2,
		PH_TLEN_LO    = 4'd3,
		PH_TOPIC      = 4'd4,
		PH_PID_HI     = 4'd5,
		PH_PID_LO     = 4'd6,
		PH_PAYLOAD    = 4'd7,
		PH_CONN_FLAGS = 4'd8,
		PH_CONN_CODE  = 4'd9,
		PH_OTHER      = 4'd10,
		PH_DROP       = 4'd11
	} ph_t;

	typedef enum logic [2:0] {
		ROLE_TYPE    = 3'd0,
		ROLE_LEN     = 3'd1,
		ROLE_TLEN    = 3'd2,
		ROLE_TOPIC   = 3'd3,
		ROLE_PID     = 3'd4,
		ROLE_PAYLOAD = 3'd5,
		ROLE_OTHER   = 3'd6,
		ROLE_DROP    = 3'd7
	} role_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_BAD_LENGTH  = 4'd1,
		ST_SHORT_PUB   = 4'd2,
		ST_TOPIC_OVR   = 4'd3,
		ST_TOPIC_LONG  = 4'd4,
		ST_BAD_UTF8    = 4'd5,
		ST_QOS3        = 4'd6,
		ST_NO_ID       = 4'd7,
		ST_OVERSIZED   = 4'd8,
		ST_SHORT_CONN  = 4'd9
	} st_t;

	// class of the open multibyte sequence, sets the next byte's allowed range
	typedef enum logic [2:0] {
		U8_ANY = 3'd0,
		U8_E0  = 3'd1,
		U8_ED  = 3'd2,
		U8_F0  = 3'd3,
		U8_F4  = 3'd4
	} u8cls_t;

	typedef struct packed {
		u8cls_t     cls;
		logic [1:0] cnt;
	} utf8_t;

	typedef struct packed {
		logic [DATA_W-1:0]  data;
		role_t              role;
		logic [3:0]         packet_type;
		logic [3:0]         packet_flags;
		logic [RLEN_W-1:0]  remaining_length;
		logic [TOPIC_W-1:0] topic_length;
		logic [PID_W-1:0]   pkt_id;
		logic [7:0]         ack_code;
		logic               sess_flag;
		logic               packet_end;
		st_t                status;
	} mip_res_t;

endpackage

// ----- hw/rtl/mip_utf8.sv -----
// Strict UTF-8 byte checker for PUBLISH topics (no NUL, overlong, surrogate).
// Depends on mip_pkg.
module mip_utf8 import mip_pkg::*; (
	input  utf8_t       cur,
	input  logic [7:0]  b,
	output logic        ok,
	output utf8_t       nxt
);

	logic [7:0] lo;
	logic [7:0] hi;

	always_comb begin
		lo = 8'h80;
		hi = 8'hBF;
		unique case (cur.cls)
			U8_E0:   lo = 8'hA0;
			U8_ED:   hi = 8'h9F;
			U8_F0:   lo = 8'h90;
			U8_F4:   hi = 8'h8F;
			default: ;
		endcase
	end

	always_comb begin
		ok  = 1'b0;
		nxt = cur;
		if (cur.cnt == 2'd0) begin
			if (b == 8'h00) begin
				ok = 1'b0;
			end else if (b < 8'h80) begin
				ok = 1'b1;
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				ok  = 1'b1;
				nxt = '{cls: U8_ANY, cnt: 2'd1};
			end else if (b == 8'hE0) begin
				ok  = 1'b1;
				nxt = '{cls: U8_E0, cnt: 2'd2};
			end else if (b == 8'hED) begin
				ok  = 1'b1;
				nxt = '{cls: U8_ED, cnt: 2'd2};
			end else if (b >= 8'hE1 && b <= 8'hEF) begin
				ok  = 1'b1;
				nxt = '{cls: U8_ANY, cnt: 2'd2};
			end else if (b == 8'hF0) begin
				ok  = 1'b1;
				nxt = '{cls: U8_F0, cnt: 2'd3};
			end else if (b >= 8'hF1 && b <= 8'hF3) begin
				ok  = 1'b1;
				nxt = '{cls: U8_ANY, cnt: 2'd3};
			end else if (b == 8'hF4) begin
				ok  = 1'b1;
				nxt = '{cls: U8_F4, cnt: 2'd3};
			end
		end else if (b >= lo && b <= hi) begin
			ok  = 1'b1;
			nxt = '{cls: U8_ANY, cnt: cur.cnt - 2'd1};
		end
	end

endmodule

// ----- hw/rtl/mip_core.sv -----
// Parser state and per-byte next-state logic; produces one result per step.
// Depends on mip_pkg and mip_utf8.
module mip_core import mip_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [DATA_W-1:0]    rx,
	input  logic [PKT_LEN_W-1:0] max_packet_len,
	input  logic [TOPIC_W-1:0]   max_topic_len,
	output mip_res_t             res
);

	ph_t                phase_q, phase_n;
	logic [RLEN_W-1:0]  acc_q, acc_n;
	logic [1:0]         idx_q, idx_n;
	logic [RLEN_W-1:0]  bbl_q, bbl_n;
	logic [7:0]         flags_q, flags_n;
	logic [TOPIC_W-1:0] htl_q, htl_n;
	logic [PID_W-1:0]   pid_q, pid_n;
	utf8_t              utf8_q, utf8_n;
	st_t                err_q, err_n;
	logic               halted_q, halted_n;
	logic [7:0]         ack_q, ack_n;
	logic               sess_q, sess_n;

	role_t              role_c;
	logic               end_c;

	logic [RLEN_W-1:0]  len_bits;
	logic [RLEN_W-1:0]  acc_new;
	logic [RLEN_W:0]    total;
	logic [RLEN_W-1:0]  bbl_dec;
	logic [RLEN_W-1:0]  consumed;
	logic [TOPIC_W-1:0] htl_full;
	logic [TOPIC_W-1:0] htl_cur;
	logic [TOPIC_W:0]   tl_plus2;
	logic [TOPIC_W:0]   tl_plus4;
	logic               topic_ovr;
	logic               id_short;
	logic               topic_done;
	logic [1:0]         qos;
	logic               qos_id;
	logic [3:0]         ptype;
	logic               u_ok;
	utf8_t              u_nxt;

	function automatic st_t set_err(st_t cur, st_t code);
		return (cur == ST_OK) ? code : cur;
	endfunction

	function automatic st_t topic_end_err(st_t e, logic open, logic [1:0] q, logic shrt);
		st_t r;
		r = e;
		if (open)
			r = set_err(r, ST_BAD_UTF8);
		if (q == QOS_3)
			r = set_err(r, ST_QOS3);
		if ((q == QOS_1 || q == QOS_2) && shrt)
			r = set_err(r, ST_NO_ID);
		return r;
	endfunction

	mip_utf8 u_utf8 (
		.cur (utf8_q),
		.b   (rx),
		.ok  (u_ok),
		.nxt (u_nxt)
	);

	always_comb begin
		case (idx_q)
			2'd0:    len_bits = {21'd0, rx[6:0]};
			2'd1:    len_bits = {14'd0, rx[6:0], 7'd0};
			2'd2:    len_bits = {7'd0, rx[6:0], 14'd0};
			default: len_bits = {rx[6:0], 21'd0};
		endcase
	end

	assign acc_new    = acc_q | len_bits;
	assign total      = {1'b0, acc_new} + {27'd0, 2'd2} + {27'd0, idx_q};
	assign bbl_dec    = (bbl_q != '0) ? bbl_q - 28'd1 : bbl_q;
	assign consumed   = acc_q - bbl_dec;
	assign htl_full   = {htl_q[15:8], rx};
	assign htl_cur    = (phase_q == PH_TLEN_LO) ? htl_full : htl_q;
	assign tl_plus2   = {1'b0, htl_cur} + 17'd2;
	assign tl_plus4   = {1'b0, htl_cur} + 17'd4;
	assign topic_ovr  = {11'd0, tl_plus2} > acc_q;
	assign id_short   = {11'd0, tl_plus4} > acc_q;
	assign topic_done = consumed == {11'd0, tl_plus2};
	assign qos        = flags_q[2:1];
	assign qos_id     = (qos == QOS_1) || (qos == QOS_2);
	assign ptype      = flags_q[7:4];

	always_comb begin
		phase_n  = phase_q;
		acc_n    = acc_q;
		idx_n    = idx_q;
		bbl_n    = bbl_q;
		flags_n  = flags_q;
		htl_n    = htl_q;
		pid_n    = pid_q;
		utf8_n   = utf8_q;
		err_n    = err_q;
		halted_n = halted_q;
		ack_n    = ack_q;
		sess_n   = sess_q;
		role_c   = ROLE_OTHER;
		end_c    = 1'b0;

		if (halted_q) begin
			role_c = ROLE_DROP;
		end else if (phase_q == PH_TYPE) begin
			flags_n = rx;
			acc_n   = '0;
			idx_n   = '0;
			bbl_n   = '0;
			htl_n   = '0;
			pid_n   = '0;
			utf8_n  = '{cls: U8_ANY, cnt: 2'd0};
			err_n   = ST_OK;
			ack_n   = '0;
			sess_n  = 1'b0;
			phase_n = PH_LEN;
			role_c  = ROLE_TYPE;
		end else if (phase_q == PH_LEN) begin
			role_c = ROLE_LEN;
			acc_n  = acc_new;
			if (rx[7]) begin
				if (idx_q == 2'd3) begin
					halted_n = 1'b1;
					err_n    = set_err(err_q, ST_BAD_LENGTH);
				end else begin
					idx_n = idx_q + 2'd1;
				end
			end else begin
				bbl_n = acc_new;
				if (total > {12'd0, max_packet_len}) begin
					err_n   = set_err(err_q, ST_OVERSIZED);
					phase_n = PH_DROP;
				end else if (ptype == T_PUBLISH) begin
					if (acc_new < 28'd2)
						err_n = set_err(err_q, ST_SHORT_PUB);
					phase_n = PH_TLEN_HI;
				end else if (ptype == T_CONNACK) begin
					if (acc_new < 28'd2) begin
						err_n   = set_err(err_q, ST_SHORT_CONN);
						phase_n = PH_OTHER;
					end else begin
						phase_n = PH_CONN_FLAGS;
					end
				end else if (ptype >= T_ACK_FIRST && ptype <= T_ACK_LAST &&
					acc_new >= 28'd2) begin
					phase_n = PH_PID_HI;
				end else begin
					phase_n = PH_OTHER;
				end
				if (acc_new == '0) begin
					end_c   = 1'b1;
					phase_n = PH_TYPE;
				end
			end
		end else begin
			bbl_n = bbl_dec;
			unique case (phase_q)
				PH_DROP: role_c = ROLE_DROP;
				PH_TLEN_HI: begin
					role_c  = ROLE_TLEN;
					htl_n   = {rx, 8'd0};
					phase_n = PH_TLEN_LO;
				end
				PH_TLEN_LO: begin
					role_c = ROLE_TLEN;
					htl_n  = htl_full;
					if (topic_ovr)
						err_n = set_err(err_q, ST_TOPIC_OVR);
					else if (htl_full > max_topic_len)
						err_n = set_err(err_q, ST_TOPIC_LONG);
					utf8_n = '{cls: U8_ANY, cnt: 2'd0};
					if (htl_full == '0) begin
						err_n   = topic_end_err(err_n, 1'b0, qos, id_short);
						phase_n = qos_id ? PH_PID_HI : PH_PAYLOAD;
					end else begin
						phase_n = PH_TOPIC;
					end
				end
				PH_TOPIC: begin
					role_c = ROLE_TOPIC;
					if (err_q == ST_OK) begin
						utf8_n = u_nxt;
						if (!u_ok)
							err_n = ST_BAD_UTF8;
					end
					if (topic_done) begin
						err_n   = topic_end_err(err_n, utf8_n.cnt != 2'd0, qos, id_short);
						phase_n = qos_id ? PH_PID_HI : PH_PAYLOAD;
					end
				end
				PH_PID_HI: begin
					role_c  = ROLE_PID;
					pid_n   = {rx, 8'd0};
					phase_n = PH_PID_LO;
				end
				PH_PID_LO: begin
					role_c  = ROLE_PID;
					pid_n   = {pid_q[15:8], rx};
					phase_n = (ptype == T_PUBLISH) ? PH_PAYLOAD : PH_OTHER;
				end
				PH_PAYLOAD: role_c = ROLE_PAYLOAD;
				PH_CONN_FLAGS: begin
					sess_n  = rx[0];
					phase_n = PH_CONN_CODE;
				end
				PH_CONN_CODE: begin
					ack_n   = rx;
					phase_n = PH_OTHER;
				end
				default: ;
			endcase
			if (bbl_dec == '0) begin
				end_c = 1'b1;
				if (phase_n == PH_TLEN_LO)
					htl_n = '0;
				if (phase_n == PH_PID_LO)
					pid_n = '0;
				phase_n = PH_TYPE;
			end
		end
	end

	always_comb begin
		res.data             = rx;
		res.role             = role_c;
		res.packet_type      = flags_n[7:4];
		res.packet_flags     = flags_n[3:0];
		res.remaining_length = acc_n;
		res.topic_length     = (phase_n == PH_TLEN_LO) ? '0 : htl_n;
		res.pkt_id           = (phase_n == PH_PID_LO || err_n != ST_OK) ? '0 : pid_n;
		res.ack_code         = ack_n;
		res.sess_flag        = sess_n;
		res.packet_end       = end_c;
		res.status           = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			acc_q    <= '0;
			idx_q    <= '0;
			bbl_q    <= '0;
			flags_q  <= '0;
			htl_q    <= '0;
			pid_q    <= '0;
			utf8_q   <= '{cls: U8_ANY, cnt: 2'd0};
			err_q    <= ST_OK;
			halted_q <= 1'b0;
			ack_q    <= '0;
			sess_q   <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			acc_q    <= acc_n;
			idx_q    <= idx_n;
			bbl_q    <= bbl_n;
			flags_q  <= flags_n;
			htl_q    <= htl_n;
			pid_q    <= pid_n;
			utf8_q   <= utf8_n;
			err_q    <= err_n;
			halted_q <= halted_n;
			ack_q    <= ack_n;
			sess_q   <= sess_n;
		end
	end

`ifndef SYNTH
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt released without reset");

	a_drop_oversized: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DROP |-> err_q == ST_OVERSIZED)
		else $error("drop phase without oversized status");

	a_body_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_TYPE && phase_q != PH_LEN) |-> bbl_q != '0)
		else $error("body phase with no bytes left");

	a_topic_publish: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.role == ROLE_TOPIC) |-> res.packet_type == T_PUBLISH)
		else $error("topic beat outside PUBLISH");
`endif

endmodule

// ----- hw/rtl/mqtt_inbound_packet_parser.sv -----
// Inbound MQTT 3.1.1 byte parser: one result beat per input byte.
// Path: input reg, then result reg; parser state updates as the input reg drains.
// Throughput: 1 byte per cycle while out_ready keeps the result reg draining.
// Reset: async active low; parser idle, limits 1024 / 127, no clearing pass.
// A continuation bit on the fourth length byte halts parsing until reset.
// Depends on mip_pkg and mip_core.
module mqtt_inbound_packet_parser import mip_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [PKT_LEN_W-1:0] cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [DATA_W-1:0]    rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    data,
	output logic [2:0]           role,
	output logic [3:0]           packet_type,
	output logic [3:0]           packet_flags,
	output logic [RLEN_W-1:0]    remaining_length,
	output logic [TOPIC_W-1:0]   topic_length,
	output logic [PID_W-1:0]     pkt_id,
	output logic [7:0]           ack_code,
	output logic                 sess_flag,
	output logic                 packet_end,
	output logic [3:0]           status
);

	logic [PKT_LEN_W-1:0] max_packet_len_q;
	logic [TOPIC_W-1:0]   max_topic_len_q;

	logic                 valid_s1;
	logic [DATA_W-1:0]    byte_s1;
	logic                 valid_s2;
	mip_res_t             res_s2;
	mip_res_t             res;
	logic                 advance;
	logic                 step;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_packet_len_q <= MAX_PACKET_LEN_RST;
			max_topic_len_q  <= MAX_TOPIC_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MAX_PACKET_LEN: max_packet_len_q <= cfg_wdata;
				REG_MAX_TOPIC_LEN:  max_topic_len_q  <= cfg_wdata[TOPIC_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			byte_s1 <= rx_byte;
		if (step)
			res_s2 <= res;
	end

	mip_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.rx             (byte_s1),
		.max_packet_len (max_packet_len_q),
		.max_topic_len  (max_topic_len_q),
		.res            (res)
	);

	assign out_valid        = valid_s2;
	assign data             = res_s2.data;
	assign role             = res_s2.role;
	assign packet_type      = res_s2.packet_type;
	assign packet_flags     = res_s2.packet_flags;
	assign remaining_length = res_s2.remaining_length;
	assign topic_length     = res_s2.topic_length;
	assign pkt_id           = res_s2.pkt_id;
	assign ack_code         = res_s2.ack_code;
	assign sess_flag        = res_s2.sess_flag;
	assign packet_end       = res_s2.packet_end;
	assign status           = res_s2.status;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for mqtt_inbound_packet_parser: streams MQTT packets in,
// predicts the tag of every byte and compares each result beat as it leaves.
// Depends on mip_pkg and the parser RTL.
module tb_top;
	import mip_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;

	typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [PKT_LEN_W-1:0] cfg_wdata;
	logic                 in_valid;
	logic                 in_ready;
	logic [DATA_W-1:0]    rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [DATA_W-1:0]    data;
	logic [2:0]           role;
	logic [3:0]           packet_type;
	logic [3:0]           packet_flags;
	logic [RLEN_W-1:0]    remaining_length;
	logic [TOPIC_W-1:0]   topic_length;
	logic [PID_W-1:0]     pkt_id;
	logic [7:0]           ack_code;
	logic                 sess_flag;
	logic                 packet_end;
	logic [3:0]           status;

	mqtt_inbound_packet_parser dut (.*);

	// parser shadow: limits and running state
	logic [PKT_LEN_W-1:0] lim_pkt;
	logic [TOPIC_W-1:0]   lim_topic;
	ph_t                  stage;
	int unsigned          rlen_acc;
	int unsigned          len_idx;
	int unsigned          body_left;
	logic [7:0]           type_flags;
	int unsigned          topic_len_h;
	int unsigned          pid_h;
	u8cls_t               u8_cls;
	logic [1:0]           u8_cnt;
	st_t                  pkt_err;
	logic                 stopped;
	logic [7:0]           conn_code;
	logic                 conn_sp;

	mip_res_t    tagged_bytes[$];
	int unsigned tag_errors;
	int unsigned tags_checked;
	int unsigned bytes_sent;
	int unsigned packets_sent;
	int unsigned settings_used;
	int unsigned cycles;
	logic [15:0] status_seen;
	logic [7:0]  roles_seen;

	// sender and receiver pacing
	logic        gapless;
	int unsigned burst_left;
	sink_mode_t  sink_mode;
	int unsigned hold_asked;
	int unsigned hold_taken;
	int unsigned hold_left;
	int unsigned pat_cnt;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("run timed out after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	function automatic void note_error(input st_t e);
		if (pkt_err == ST_OK)
			pkt_err = e;
	endfunction

	function automatic void close_topic();
		logic [1:0] qos;
		qos = type_flags[2:1];
		if (u8_cnt != 2'd0)
			note_error(ST_BAD_UTF8);
		if (qos == QOS_3)
			note_error(ST_QOS3);
		if ((qos == QOS_1 || qos == QOS_2) && 4 + topic_len_h > rlen_acc)
			note_error(ST_NO_ID);
		stage = (qos == QOS_1 || qos == QOS_2) ? PH_PID_HI : PH_PAYLOAD;
	endfunction

	function automatic mip_res_t tag_byte(input logic [7:0] b);
		mip_res_t    r;
		role_t       rl;
		logic        fin;
		logic        ok;
		logic [7:0]  lo;
		logic [7:0]  hi;
		int unsigned used;
		int unsigned total;
		rl  = ROLE_OTHER;
		fin = 1'b0;
		if (stopped) begin
			rl = ROLE_DROP;
		end else if (stage == PH_TYPE) begin
			type_flags  = b;
			rlen_acc    = 0;
			len_idx     = 0;
			body_left   = 0;
			topic_len_h = 0;
			pid_h       = 0;
			u8_cls      = U8_ANY;
			u8_cnt      = 2'd0;
			pkt_err     = ST_OK;
			conn_code   = 8'h00;
			conn_sp     = 1'b0;
			stage       = PH_LEN;
			rl          = ROLE_TYPE;
		end else if (stage == PH_LEN) begin
			rl = ROLE_LEN;
			rlen_acc |= int'(b[6:0]) << (7 * len_idx);
			if (b[7]) begin
				if (len_idx >= 3) begin
					stopped = 1'b1;
					note_error(ST_BAD_LENGTH);
				end else begin
					len_idx++;
				end
			end else begin
				total     = 2 + len_idx + rlen_acc;
				body_left = rlen_acc;
				if (total > lim_pkt) begin
					note_error(ST_OVERSIZED);
					stage = PH_DROP;
				end else if (type_flags[7:4] == T_PUBLISH) begin
					if (rlen_acc < 2)
						note_error(ST_SHORT_PUB);
					stage = PH_TLEN_HI;
				end else if (type_flags[7:4] == T_CONNACK) begin
					if (rlen_acc < 2) begin
						note_error(ST_SHORT_CONN);
						stage = PH_OTHER;
					end else begin
						stage = PH_CONN_FLAGS;
					end
				end else if (type_flags[7:4] >= T_ACK_FIRST && type_flags[7:4] <= T_ACK_LAST
						&& rlen_acc >= 2) begin
					stage = PH_PID_HI;
				end else begin
					stage = PH_OTHER;
				end
				if (rlen_acc == 0) begin
					fin   = 1'b1;
					stage = PH_TYPE;
				end
			end
		end else begin
			if (body_left > 0)
				body_left--;
			used = rlen_acc - body_left;
			case (stage)
				PH_DROP: rl = ROLE_DROP;
				PH_TLEN_HI: begin
					rl          = ROLE_TLEN;
					topic_len_h = int'(b) << 8;
					stage       = PH_TLEN_LO;
				end
				PH_TLEN_LO: begin
					rl = ROLE_TLEN;
					topic_len_h |= int'(b);
					if (2 + topic_len_h > rlen_acc)
						note_error(ST_TOPIC_OVR);
					else if (topic_len_h > lim_topic)
						note_error(ST_TOPIC_LONG);
					u8_cls = U8_ANY;
					u8_cnt = 2'd0;
					if (topic_len_h == 0)
						close_topic();
					else
						stage = PH_TOPIC;
				end
				PH_TOPIC: begin
					rl = ROLE_TOPIC;
					if (pkt_err == ST_OK) begin
						ok = 1'b1;
						if (u8_cnt == 2'd0) begin
							if (b == 8'h00) begin
								ok = 1'b0;
							end else if (b < 8'h80) begin
								ok = 1'b1;
							end else if (b >= 8'hC2 && b <= 8'hDF) begin
								u8_cnt = 2'd1;
							end else if (b == 8'hE0) begin
								u8_cls = U8_E0;
								u8_cnt = 2'd2;
							end else if (b == 8'hED) begin
								u8_cls = U8_ED;
								u8_cnt = 2'd2;
							end else if (b >= 8'hE1 && b <= 8'hEF) begin
								u8_cnt = 2'd2;
							end else if (b == 8'hF0) begin
								u8_cls = U8_F0;
								u8_cnt = 2'd3;
							end else if (b >= 8'hF1 && b <= 8'hF3) begin
								u8_cnt = 2'd3;
							end else if (b == 8'hF4) begin
								u8_cls = U8_F4;
								u8_cnt = 2'd3;
							end else begin
								ok = 1'b0;
							end
						end else begin
							lo = 8'h80;
							hi = 8'hBF;
							case (u8_cls)
								U8_E0: lo = 8'hA0;
								U8_ED: hi = 8'h9F;
								U8_F0: lo = 8'h90;
								U8_F4: hi = 8'h8F;
								default: ;
							endcase
							if (b < lo || b > hi) begin
								ok = 1'b0;
							end else begin
								u8_cls = U8_ANY;
								u8_cnt = u8_cnt - 2'd1;
							end
						end
						if (!ok)
							note_error(ST_BAD_UTF8);
					end
					if (used == 2 + topic_len_h)
						close_topic();
				end
				PH_PID_HI: begin
					rl    = ROLE_PID;
					pid_h = int'(b) << 8;
					stage = PH_PID_LO;
				end
				PH_PID_LO: begin
					rl = ROLE_PID;
					pid_h |= int'(b);
					stage = (type_flags[7:4] == T_PUBLISH) ? PH_PAYLOAD : PH_OTHER;
				end
				PH_PAYLOAD: rl = ROLE_PAYLOAD;
				PH_CONN_FLAGS: begin
					conn_sp = b[0];
					stage   = PH_CONN_CODE;
				end
				PH_CONN_CODE: begin
					conn_code = b;
					stage     = PH_OTHER;
				end
				default: ;
			endcase
			if (body_left == 0) begin
				fin = 1'b1;
				if (stage == PH_TLEN_LO)
					topic_len_h = 0;
				if (stage == PH_PID_LO)
					pid_h = 0;
				stage = PH_TYPE;
			end
		end
		r.data             = b;
		r.role             = rl;
		r.packet_type      = type_flags[7:4];
		r.packet_flags     = type_flags[3:0];
		r.remaining_length = rlen_acc[RLEN_W-1:0];
		r.topic_length     = (stage == PH_TLEN_LO) ? '0 : topic_len_h[15:0];
		r.pkt_id           = (stage == PH_PID_LO || pkt_err != ST_OK) ? '0 : pid_h[15:0];
		r.ack_code         = conn_code;
		r.sess_flag        = conn_sp;
		r.packet_end       = fin;
		r.status           = pkt_err;
		return r;
	endfunction

	function automatic string show_tag(input mip_res_t t);
		return $sformatf({"byte=%h role=%0d type=%0d flags=%h rlen=%0d tlen=%0d",
			" id=%h ack=%h sp=%b end=%b st=%0d"},
			t.data, t.role, t.packet_type, t.packet_flags, t.remaining_length,
			t.topic_length, t.pkt_id, t.ack_code, t.sess_flag, t.packet_end, t.status);
	endfunction

	// result checker
	always @(posedge clk) begin
		mip_res_t got;
		mip_res_t want;
		logic     wrong;
		if (arst_n && out_valid && out_ready) begin
			got.data             = data;
			got.role             = role_t'(role);
			got.packet_type      = packet_type;
			got.packet_flags     = packet_flags;
			got.remaining_length = remaining_length;
			got.topic_length     = topic_length;
			got.pkt_id           = pkt_id;
			got.ack_code         = ack_code;
			got.sess_flag        = sess_flag;
			got.packet_end       = packet_end;
			got.status           = st_t'(status);
			tags_checked++;
			if (tagged_bytes.size() == 0) begin
				tag_errors++;
				if (tag_errors <= 10)
					$display("%0t: beat with nothing pending: %s", $realtime, show_tag(got));
			end else begin
				want  = tagged_bytes.pop_front();
				wrong = (got.data !== want.data) || (got.role !== want.role)
					|| (got.packet_type !== want.packet_type)
					|| (got.packet_flags !== want.packet_flags)
					|| (got.remaining_length !== want.remaining_length)
					|| (got.topic_length !== want.topic_length)
					|| (got.pkt_id !== want.pkt_id)
					|| (got.ack_code !== want.ack_code)
					|| (got.sess_flag !== want.sess_flag)
					|| (got.packet_end !== want.packet_end)
					|| (got.status !== want.status);
				if (wrong) begin
					tag_errors++;
					if (tag_errors <= 10) begin
						$display("%0t: mismatch, exp %s", $realtime, show_tag(want));
						$display("%0t:           got %s", $realtime, show_tag(got));
					end
				end
				roles_seen[want.role] = 1'b1;
				if (want.packet_end)
					status_seen[want.status] = 1'b1;
			end
		end
	end

	// receiver: long hold on request, otherwise per sink_mode
	always @(posedge clk) begin
		if (hold_taken != hold_asked) begin
			hold_taken = hold_asked;
			hold_left  = LONG_HOLD;
		end
		pat_cnt = (pat_cnt == 6) ? 0 : pat_cnt + 1;
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (sink_mode)
				SINK_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
				SINK_PATTERN: out_ready <= (pat_cnt < 4);
				default:      out_ready <= 1'b1;
			endcase
		end
	end

	function automatic logic [7:0] rnd8(input logic [7:0] lo, input logic [7:0] hi);
		return 8'($urandom_range(int'(lo), int'(hi)));
	endfunction

	function automatic void add_header(ref logic [7:0] q[$], input logic [7:0] first,
			input int unsigned rl);
		int n;
		n = 1;
		while (n < 4 && (rl >> (7 * n)) != 0)
			n++;
		// sometimes a padded length encoding
		if ($urandom_range(0, 7) == 0)
			n = $urandom_range(n, 4);
		q.push_back(first);
		for (int i = 0; i < n; i++)
			q.push_back({i < n - 1, 7'((rl >> (7 * i)) & 32'h7F)});
	endfunction

	function automatic void build_publish(ref logic [7:0] q[$]);
		logic [7:0]  body[$];
		logic [7:0]  topic[$];
		logic [7:0]  lead;
		logic [1:0]  qos;
		int unsigned tlen;
		int unsigned rl;
		int unsigned want_len;
		int          kind;
		int          flaw;
		qos = 2'($urandom_range(0, 3));
		if (qos == QOS_3 && $urandom_range(0, 2) != 0)
			qos = QOS_1;
		want_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
		while (topic.size() < want_len) begin
			kind = $urandom_range(0, 49);
			if (kind < 30) begin
				topic.push_back(rnd8(8'h01, 8'h7F));
			end else if (kind < 36) begin
				topic.push_back(rnd8(8'hC2, 8'hDF));
				topic.push_back(rnd8(8'h80, 8'hBF));
			end else if (kind < 42) begin
				lead = rnd8(8'hE0, 8'hEF);
				topic.push_back(lead);
				topic.push_back(lead == 8'hE0 ? rnd8(8'hA0, 8'hBF) :
					lead == 8'hED ? rnd8(8'h80, 8'h9F) : rnd8(8'h80, 8'hBF));
				topic.push_back(rnd8(8'h80, 8'hBF));
			end else if (kind < 47) begin
				lead = rnd8(8'hF0, 8'hF4);
				topic.push_back(lead);
				topic.push_back(lead == 8'hF0 ? rnd8(8'h90, 8'hBF) :
					lead == 8'hF4 ? rnd8(8'h80, 8'h8F) : rnd8(8'h80, 8'hBF));
				topic.push_back(rnd8(8'h80, 8'hBF));
				topic.push_back(rnd8(8'h80, 8'hBF));
			end else if (kind == 47) begin
				topic.push_back(8'h00);
			end else begin
				topic.push_back(rnd8(8'h80, 8'hFF));
			end
		end
		// cut sequence at topic end
		if (topic.size() != 0 && $urandom_range(0, 24) == 0)
			void'(topic.pop_back());
		tlen = topic.size();
		flaw = $urandom_range(0, 15);
		if (flaw == 0) begin
			body.push_back(rnd8(8'h00, 8'hFF));
			body.push_back(rnd8(8'h00, 8'hFF));
		end else begin
			body.push_back(tlen[15:8]);
			body.push_back(tlen[7:0]);
		end
		foreach (topic[i])
			body.push_back(topic[i]);
		if (qos == QOS_1 || qos == QOS_2) begin
			body.push_back(rnd8(8'h00, 8'hFF));
			body.push_back(rnd8(8'h00, 8'hFF));
		end
		repeat ($urandom_range(0, 6))
			body.push_back(rnd8(8'h00, 8'hFF));
		rl = body.size();
		if (flaw == 1)
			rl = $urandom_range(0, 1);
		else if (flaw == 2 && (qos == QOS_1 || qos == QOS_2))
			rl = 2 + tlen + $urandom_range(0, 1);
		while (body.size() > rl)
			void'(body.pop_back());
		add_header(q, {T_PUBLISH, 1'($urandom_range(0, 1)), qos, 1'($urandom_range(0, 1))}, rl);
		foreach (body[i])
			q.push_back(body[i]);
	endfunction

	function automatic void build_short(ref logic [7:0] q[$], input logic [3:0] ptype);
		int unsigned rl;
		int          pick;
		if (ptype == T_CONNACK || (ptype >= T_ACK_FIRST && ptype <= T_ACK_LAST)) begin
			pick = $urandom_range(0, 9);
			rl   = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick == 2) ? 3 : 2;
		end else begin
			rl = $urandom_range(0, 5);
		end
		add_header(q, {ptype, 4'($urandom_range(0, 15))}, rl);
		repeat (rl)
			q.push_back(rnd8(8'h00, 8'hFF));
	endfunction

	task automatic idle(input int unsigned n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tagged_bytes.push_back(tag_byte(b));
		bytes_sent++;
	endtask

	task automatic send_packet(input logic [7:0] q[$]);
		foreach (q[i]) begin
			send_byte(q[i]);
			if (!gapless) begin
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					idle($urandom_range(1, 6));
					burst_left = $urandom_range(0, 15);
				end
			end
		end
		packets_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (tagged_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input logic [PKT_LEN_W-1:0] pkt_lim,
			input logic [TOPIC_W-1:0] topic_lim);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_MAX_PACKET_LEN;
		cfg_wdata <= pkt_lim;
		@(posedge clk);
		lim_pkt = pkt_lim;
		cfg_addr  <= REG_MAX_TOPIC_LEN;
		cfg_wdata <= PKT_LEN_W'(topic_lim);
		@(posedge clk);
		lim_topic = topic_lim;
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_random_traffic(input int unsigned n_bytes);
		logic [7:0]  pkt[$];
		int unsigned start;
		int          pick;
		int          t;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			pkt.delete();
			pick = $urandom_range(0, 19);
			if (pick < 9) begin
				build_publish(pkt);
			end else if (pick < 12) begin
				build_short(pkt, T_CONNACK);
			end else if (pick < 16) begin
				build_short(pkt, 4'($urandom_range(int'(T_ACK_FIRST), int'(T_ACK_LAST))));
			end else begin
				t = $urandom_range(0, 9);
				build_short(pkt, 4'((t < 2) ? t : t + 6));
			end
			send_packet(pkt);
		end
	endtask

	task automatic test_directed_packets();
		sink_mode = SINK_RANDOM;
		send_packet('{8'hD0, 8'h00});                       // empty body, ends on length
		send_packet('{8'h20, 8'h02, 8'h01, 8'h05});         // connack, session present
		send_packet('{8'h20, 8'h01, 8'hFF});                // connack too short
		send_packet('{8'h40, 8'h02, 8'hBE, 8'hEF});         // puback
		send_packet('{8'h62, 8'h01, 8'h77});                // pubrel without id
		send_packet('{8'h32, 8'h07, 8'h00, 8'h01, 8'h61, 8'h12, 8'h34, 8'hFF, 8'h00});
		send_packet('{8'hC0, 8'h80, 8'h80, 8'h80, 8'h00}); // padded four byte length
	endtask

	task automatic test_backpressure();
		drain();
		sink_mode = SINK_OPEN;
		gapless   = 1'b1;
		hold_asked++;
		send_random_traffic(60);
		gapless   = 1'b0;
		sink_mode = SINK_RANDOM;
		send_random_traffic(100);
	endtask

	task automatic test_wide_limits();
		drain();
		set_limits(17'h10000, 16'hFFFF);
		sink_mode = SINK_OPEN;
		gapless   = 1'b1;
		send_random_traffic(150);
		gapless   = 1'b0;
	endtask

	task automatic test_tight_limits();
		drain();
		set_limits(17'd24, 16'd0);
		sink_mode = SINK_PATTERN;
		send_random_traffic(150);
	endtask

	task automatic test_drop_everything();
		drain();
		set_limits(17'd2, 16'd4);
		sink_mode = SINK_RANDOM;
		send_random_traffic(100);
		drain();
		set_limits(17'd1, 16'd8);
		sink_mode = SINK_PATTERN;
		send_random_traffic(50);
	endtask

	task automatic test_restored_limits();
		drain();
		set_limits(MAX_PACKET_LEN_RST, MAX_TOPIC_LEN_RST);
		sink_mode = SINK_RANDOM;
		send_random_traffic(150);
	endtask

	// continuation on the fourth length byte locks the parser; must run last
	task automatic test_length_overflow();
		send_packet('{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		repeat (8)
			send_byte(rnd8(8'h00, 8'hFF));
	endtask

	initial begin
		int w;
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_addr     = '0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		rx_byte      = '0;
		out_ready    = 1'b0;
		lim_pkt      = MAX_PACKET_LEN_RST;
		lim_topic    = MAX_TOPIC_LEN_RST;
		stage        = PH_TYPE;
		rlen_acc     = 0;
		len_idx      = 0;
		body_left    = 0;
		type_flags   = 8'h00;
		topic_len_h  = 0;
		pid_h        = 0;
		u8_cls       = U8_ANY;
		u8_cnt       = 2'd0;
		pkt_err      = ST_OK;
		stopped      = 1'b0;
		conn_code    = 8'h00;
		conn_sp      = 1'b0;
		tag_errors   = 0;
		tags_checked = 0;
		bytes_sent   = 0;
		packets_sent = 0;
		settings_used = 1;
		cycles       = 0;
		status_seen  = '0;
		roles_seen   = '0;
		gapless      = 1'b0;
		burst_left   = 0;
		sink_mode    = SINK_OPEN;
		hold_asked   = 0;
		hold_taken   = 0;
		hold_left    = 0;
		pat_cnt      = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_packets();
		test_backpressure();
		test_wide_limits();
		test_tight_limits();
		test_drop_everything();
		test_restored_limits();
		test_length_overflow();

		in_valid <= 1'b0;
		for (w = 0; w < 2000 && tagged_bytes.size() != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tagged_bytes.size() != 0) begin
			$display("%0d tagged bytes never came out", tagged_bytes.size());
			tag_errors += tagged_bytes.size();
		end
		$display("%0d bytes in %0d packets under %0d limit settings, %0d beats checked, %0d bad",
			bytes_sent, packets_sent, settings_used, tags_checked, tag_errors);
		$display("roles seen %b, packet end status codes seen %b", roles_seen, status_seen);
		if (tag_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
